### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the MAC tag block.
// Each macro checks a property on the rising clock edge outside of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

### hdl/mts_pkg.sv
// Constants shared by the MAC tag block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;
  localparam int unsigned KEY_WIDTH   = 20;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned ADDR_WIDTH  = 3;
  localparam logic [31:0] PRIME_RESET = 32'd65537;
  localparam logic [31:0] PRIME_MIN   = 32'd2;
  localparam logic        REG_PRIME   = 1'b0;
endpackage
`default_nettype wire

### hdl/mts_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Carries a sideband word alongside the data. Uses no package.
`timescale 1ns / 1ps
`default_nettype none
module mts_div #(
  parameter int unsigned DW = 60,
  parameter int unsigned PW = 20,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [PW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [DW-1:0]      quotient,
  output logic [PW-1:0]      remainder,
  output logic [SW-1:0]      side_out
);
  logic          vld  [0:DW];
  logic [DW-1:0] dq   [0:DW];
  logic [PW-1:0] rem  [0:DW];
  logic [SW-1:0] side [0:DW];

  assign vld[0]  = in_valid;
  assign dq[0]   = dividend;
  assign rem[0]  = '0;
  assign side[0] = side_in;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [PW:0] trial;
    logic [PW:0] diff;
    logic        ge;
    assign trial = {rem[i], dq[i][DW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? diff[PW-1:0] : trial[PW-1:0];
      dq[i+1]   <= {dq[i][DW-2:0], ge};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[DW];
  assign quotient  = dq[DW];
  assign remainder = rem[DW];
  assign side_out  = side[DW];
endmodule
`default_nettype wire

### hdl/mac_tag_split_mod_prime.sv
// Top level of the MAC tag block: APB prime register, four divider pipelines
// and a multiply pipeline for packing. Depends on mts_pkg, mts_div and assert_macros.svh.
// A transaction passes the value and quotient dividers, then the alpha and beta
// dividers side by side, then the packing stages; one divider stage per quotient bit.
// Throughput: one transaction per cycle; busy is never high.
// Reset is synchronous and clears every valid bit; the prime returns to 65537.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mac_tag_split_mod_prime #(
  parameter int unsigned VALUE_WIDTH = 60,
  parameter int unsigned PRIME_WIDTH = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mts_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [mts_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic      [mts_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                                  pready,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [VALUE_WIDTH-1:0]           value,
  input  wire logic [mts_pkg::KEY_WIDTH-1:0]    alpha_offset_key,
  input  wire logic                             alpha_parity_key,
  input  wire logic [mts_pkg::KEY_WIDTH-1:0]    beta_offset_key,
  input  wire logic                             beta_parity_key,
  output logic                                  done,
  output logic [VALUE_WIDTH-1:0]                tag_packed,
  output logic [1:0]                            tag_bits
);
  localparam int unsigned VW   = VALUE_WIDTH;
  localparam int unsigned PW   = PRIME_WIDTH;
  localparam int unsigned KW   = mts_pkg::KEY_WIDTH;
  localparam int unsigned SUMW = ((VW > KW) ? VW : KW) + 1;
  localparam int unsigned MW   = ((3 * PW > VW) ? 3 * PW : VW) + 1;
  localparam int unsigned S1W  = 2 * KW + 2;
  localparam int unsigned S2W  = 2 * KW + 2 + PW;
  localparam int unsigned LAT  = 2 * VW + SUMW + 3;

  // Configuration register.
  logic [PW-1:0] prime;
  logic [PW-1:0] p_eff;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mts_pkg::REG_PRIME) ? mts_pkg::DATA_WIDTH'(prime) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= mts_pkg::PRIME_RESET[PW-1:0];
    end else if (psel && penable && pwrite && pready && (paddr[2] == mts_pkg::REG_PRIME)) begin
      prime <= pwdata[PW-1:0];
    end
  end

  assign p_eff = (32'(prime) < mts_pkg::PRIME_MIN) ? mts_pkg::PRIME_MIN[PW-1:0] : prime;

  assign busy = 1'b0;

  // First division: v = q*p + r.
  logic          d1_valid;
  logic [VW-1:0] d1_q;
  logic [PW-1:0] d1_r;
  logic [S1W-1:0] d1_side;

  mts_div #(.DW(VW), .PW(PW), .SW(S1W)) u_div_value (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .dividend  (value),
    .divisor   (p_eff),
    .side_in   ({alpha_offset_key, alpha_parity_key, beta_offset_key, beta_parity_key}),
    .out_valid (d1_valid),
    .quotient  (d1_q),
    .remainder (d1_r),
    .side_out  (d1_side)
  );

  // Second division: q = alpha*p + beta.
  logic           d2_valid;
  logic [VW-1:0]  d2_alpha;
  logic [PW-1:0]  d2_beta;
  logic [S2W-1:0] d2_side;

  mts_div #(.DW(VW), .PW(PW), .SW(S2W)) u_div_quot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .dividend  (d1_q),
    .divisor   (p_eff),
    .side_in   ({d1_side, d1_r}),
    .out_valid (d2_valid),
    .quotient  (d2_alpha),
    .remainder (d2_beta),
    .side_out  (d2_side)
  );

  logic [KW-1:0]   k_aoff;
  logic            k_apar;
  logic [KW-1:0]   k_boff;
  logic            k_bpar;
  logic [PW-1:0]   d2_r;
  logic [SUMW-1:0] a_sum;
  logic [SUMW-1:0] b_sum;

  assign {k_aoff, k_apar, k_boff, k_bpar, d2_r} = d2_side;
  assign a_sum = SUMW'(d2_alpha) + SUMW'(k_aoff);
  assign b_sum = SUMW'(d2_beta) + SUMW'(k_boff);

  // Final divisions of the keyed alpha and beta run side by side.
  logic            da_valid;
  logic [SUMW-1:0] da_q;
  logic [PW-1:0]   da_frac;
  logic [PW:0]     da_side;
  logic            db_valid;
  logic [SUMW-1:0] db_q;
  logic [PW-1:0]   db_frac;
  logic            db_side;

  mts_div #(.DW(SUMW), .PW(PW), .SW(PW + 1)) u_div_alpha (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .dividend  (a_sum),
    .divisor   (p_eff),
    .side_in   ({k_apar, d2_r}),
    .out_valid (da_valid),
    .quotient  (da_q),
    .remainder (da_frac),
    .side_out  (da_side)
  );

  mts_div #(.DW(SUMW), .PW(PW), .SW(1)) u_div_beta (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .dividend  (b_sum),
    .divisor   (p_eff),
    .side_in   (k_bpar),
    .out_valid (db_valid),
    .quotient  (db_q),
    .remainder (db_frac),
    .side_out  (db_side)
  );

  // Packing: alpha_frac*p*p + beta_frac*p + r over three stages.
  logic            m1_valid;
  logic [2*PW-1:0] m1_ap;
  logic [2*PW:0]   m1_bpr;
  logic [1:0]      m1_bits;
  logic            m2_valid;
  logic [3*PW-1:0] m2_app;
  logic [2*PW:0]   m2_bpr;
  logic [1:0]      m2_bits;
  logic [MW-1:0]   pack_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      m1_valid <= da_valid;
      m2_valid <= m1_valid;
      done     <= m2_valid;
    end
  end

  assign pack_sum = MW'(m2_app) + MW'(m2_bpr);

  always_ff @(posedge clk) begin
    m1_ap      <= {{PW{1'b0}}, da_frac} * {{PW{1'b0}}, p_eff};
    m1_bpr     <= (2*PW+1)'({{PW{1'b0}}, db_frac} * {{PW{1'b0}}, p_eff})
                  + (2*PW+1)'(da_side[PW-1:0]);
    m1_bits    <= {da_q[0] ^ da_side[PW], db_q[0] ^ db_side};
    m2_app     <= {{PW{1'b0}}, m1_ap} * {{(2*PW){1'b0}}, p_eff};
    m2_bpr     <= m1_bpr;
    m2_bits    <= m1_bits;
    tag_packed <= pack_sum[VW-1:0];
    tag_bits   <= m2_bits;
  end

  `ASSERT_CLK(a_latency, clk, rst, (start && !busy) |-> ##LAT done)
  `ASSERT_CLK(a_lanes_aligned, clk, rst, da_valid == db_valid)
  `ASSERT_NEVER(a_never_busy, clk, rst, busy)
endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the MAC tag block mac_tag_split_mod_prime.
// Drives tags through the command port and the prime register over APB, and
// checks every result against an in-bench predictor. Depends on mts_pkg.
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned VW = 60;
  localparam int unsigned PW = 20;
  localparam int unsigned KW = mts_pkg::KEY_WIDTH;
  localparam int unsigned AW = mts_pkg::ADDR_WIDTH;
  localparam int unsigned DW = mts_pkg::DATA_WIDTH;
  localparam int unsigned LATENCY = 2 * VW + VW + 4;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
  localparam logic [AW-1:0] PRIME_ADDR = AW'(4 * mts_pkg::REG_PRIME);

  typedef struct packed {
    logic [VW-1:0] value;
    logic [KW-1:0] alpha_off;
    logic          alpha_par;
    logic [KW-1:0] beta_off;
    logic          beta_par;
  } tag_req_t;

  typedef struct packed {
    logic [VW-1:0] packed_tag;
    logic [1:0]    bits;
  } tag_res_t;

  class tag_scoreboard;
    tag_res_t    pending_tags[$];
    logic [PW-1:0] prime_reg;
    int          mismatches;

    function new();
      prime_reg = PW'(mts_pkg::PRIME_RESET);
      mismatches = 0;
    endfunction

    // Splits alpha or beta with its key: returns the fraction, sets the bit.
    function logic [63:0] key_fold(logic [63:0] part, logic [63:0] off,
                                   logic par, logic [63:0] p,
                                   output logic bit_out);
      logic [63:0] s;
      logic [63:0] sq;
      s = part + off;
      sq = s / p;
      bit_out = sq[0] ^ par;
      return s % p;
    endfunction

    function void note_request(tag_req_t req);
      logic [63:0] p, v, r, q, a_frac, b_frac, packed_sum;
      logic a_bit, b_bit;
      tag_res_t res;
      p = (prime_reg < 2) ? 64'd2 : 64'(prime_reg);
      v = 64'(req.value);
      r = v % p;
      q = v / p;
      a_frac = key_fold(q / p, 64'(req.alpha_off), req.alpha_par, p, a_bit);
      b_frac = key_fold(q % p, 64'(req.beta_off), req.beta_par, p, b_bit);
      packed_sum = a_frac * p * p + b_frac * p + r;
      res.packed_tag = packed_sum[VW-1:0];
      res.bits = {a_bit, b_bit};
      pending_tags = {pending_tags, res};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(tag_res_t got);
      tag_res_t want;
      if (pending_tags.size() == 0) begin
        report("unexpected transaction", 64'(got.packed_tag), 64'd0);
      end else begin
        want = pending_tags.pop_front();
        if (got.packed_tag !== want.packed_tag)
          report("tag_packed", 64'(got.packed_tag), 64'(want.packed_tag));
        if (got.bits !== want.bits)
          report("tag_bits", 64'(got.bits), 64'(want.bits));
      end
    endtask
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata, prdata;
  logic pready, start, busy, done;
  logic [VW-1:0] value, tag_packed;
  logic [KW-1:0] alpha_offset_key, beta_offset_key;
  logic alpha_parity_key, beta_parity_key;
  logic [1:0] tag_bits;

  tag_scoreboard sb;
  int idle_pct;
  int stall_cycles;

  mac_tag_split_mod_prime #(.VALUE_WIDTH(VW), .PRIME_WIDTH(PW)) u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .value(value),
    .alpha_offset_key(alpha_offset_key), .alpha_parity_key(alpha_parity_key),
    .beta_offset_key(beta_offset_key), .beta_parity_key(beta_parity_key),
    .done(done), .tag_packed(tag_packed), .tag_bits(tag_bits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Checking and watchdog, both at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result('{packed_tag: tag_packed, bits: tag_bits});
      end
      if ((start && !busy) || done || (psel && penable))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task write_prime(logic [DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PRIME_ADDR;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.prime_reg = data[PW-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Presents one request and holds it until accepted. Called at a falling edge.
  task send_tag(tag_req_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    {value, alpha_offset_key, alpha_parity_key, beta_offset_key, beta_parity_key} <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task end_burst();
    start <= 1'b0;
    while (sb.pending_tags.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic tag_req_t random_tag(logic [PW-1:0] p);
    tag_req_t req;
    logic [63:0] pp;
    req.value = VW'({$urandom, $urandom});
    // Shorter values keep alpha and beta small to reach both quotient bounds.
    case ($urandom_range(3))
      0: req.value = req.value >> $urandom_range(VW - 1);
      1: begin
        pp = (p < 2) ? 64'd2 : 64'(p);
        req.value = VW'(pp * pp * $urandom_range(3) + $urandom_range(3) * pp - 1);
      end
      default: ;
    endcase
    req.alpha_off = KW'($urandom);
    req.alpha_par = 1'($urandom_range(1));
    req.beta_off = KW'($urandom);
    req.beta_par = 1'($urandom_range(1));
    return req;
  endfunction

  logic [PW-1:0] primes[8];

  initial begin
    logic [VW-1:0] ones;
    sb = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; value = '0; alpha_offset_key = '0; alpha_parity_key = 1'b0;
    beta_offset_key = '0; beta_parity_key = 1'b0;
    stall_cycles = 0;
    idle_pct = 0;
    ones = '1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset prime, extremes of each field.
    send_tag('{value: '0, alpha_off: '0, alpha_par: 1'b0, beta_off: '0, beta_par: 1'b0});
    send_tag('{value: ones, alpha_off: '1, alpha_par: 1'b1, beta_off: '1, beta_par: 1'b1});
    send_tag('{value: ones, alpha_off: '0, alpha_par: 1'b0, beta_off: '1, beta_par: 1'b1});
    send_tag('{value: VW'(65537) * 65537 - 1, alpha_off: '1, alpha_par: 1'b0,
               beta_off: '0, beta_par: 1'b1});
    end_burst();
    // A prime below two acts as two.
    write_prime(DW'(0));
    send_tag('{value: ones, alpha_off: '1, alpha_par: 1'b1, beta_off: KW'(1),
               beta_par: 1'b0});
    send_tag('{value: VW'(7), alpha_off: KW'(1), alpha_par: 1'b0, beta_off: '1,
               beta_par: 1'b1});
    end_burst();
    write_prime(DW'(1));
    send_tag('{value: ones, alpha_off: '0, alpha_par: 1'b0, beta_off: '0, beta_par: 1'b0});
    send_tag('{value: VW'(5), alpha_off: KW'(3), alpha_par: 1'b1, beta_off: KW'(2),
               beta_par: 1'b0});
    end_burst();
    write_prime(32'hFFFFF);
    send_tag('{value: ones, alpha_off: '1, alpha_par: 1'b1, beta_off: '1, beta_par: 1'b1});
    send_tag('{value: '0, alpha_off: '1, alpha_par: 1'b0, beta_off: '1, beta_par: 1'b0});
    send_tag('{value: VW'(64'hFFFFF * 64'hFFFFF - 1), alpha_off: KW'(1), alpha_par: 1'b1,
               beta_off: KW'(1), beta_par: 1'b1});
    end_burst();
    // Bits above the field are dropped.
    write_prime(32'hFFF0_0003);
    send_tag('{value: ones, alpha_off: '1, alpha_par: 1'b1, beta_off: KW'(5),
               beta_par: 1'b0});
    end_burst();

    primes = '{20'd2, 20'd3, 20'd65537, 20'hFFFFF, 20'd1, 20'd1021, 20'd7919, 20'd999983};
    for (int ph = 0; ph < 8; ph++) begin
      write_prime({12'($urandom), primes[ph]});
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 14;
        default: idle_pct = 49;
      endcase
      for (int i = 0; i < 110; i++) begin
        send_tag(random_tag(primes[ph]));
      end
      end_burst();
    end

    if (sb.mismatches == 0 && sb.pending_tags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
